/* hdl/ssbd_pkg.sv */
// Shared constants for the supersample box downsampler.
`default_nettype none

package ssbd_pkg;

	localparam int DEF_MAX_OUT_SIZE = 1024;
	localparam int DEF_MAX_FACTOR   = 8;
	localparam int DEF_CHANNEL_BITS = 12;

	localparam int FACTOR_W   = 4;
	localparam int OUT_SIZE_W = 11;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;

	localparam int RST_FACTOR   = 2;
	localparam int RST_OUT_SIZE = 1024;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FACTOR   = 2'd0,
		REG_OUT_SIZE = 2'd1
	} reg_idx_t;

endpackage

`default_nettype wire

/* hdl/supersample_box_downsample.sv */
// Top level: box-filter downsampler for a supersampled RGB sample stream.
`default_nettype none

// Samples arrive in raster order over an (out_size*factor)-square frame. Each one inside
// an output window is added into a per-column sum memory (one read, one write-back a
// cycle, with a bypass for back-to-back hits on the same column). The sample that closes
// an output window launches a restoring divider for all three channels; the input stalls
// while the divider runs and until its result is handed to the output register. All other
// samples go at one per clock while the divider is idle. A write to the factor or out-size
// register restarts the frame at its first sample.
module supersample_box_downsample import ssbd_pkg::*; #(
	parameter int MAX_OUT_SIZE = DEF_MAX_OUT_SIZE,
	parameter int MAX_FACTOR   = DEF_MAX_FACTOR,
	parameter int CHANNEL_BITS = DEF_CHANNEL_BITS,
	localparam int AW = (MAX_OUT_SIZE > 1) ? $clog2(MAX_OUT_SIZE) : 1
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    cfg_valid,
	output logic                         cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [CFG_DATA_W-1:0]   cfg_data,
	input  wire logic                    sample_valid,
	output logic                         sample_stall,
	input  wire logic [CHANNEL_BITS-1:0] red_in,
	input  wire logic [CHANNEL_BITS-1:0] green_in,
	input  wire logic [CHANNEL_BITS-1:0] blue_in,
	output logic                         result_valid,
	input  wire logic                    result_stall,
	output logic [CHANNEL_BITS-1:0]      red_out,
	output logic [CHANNEL_BITS-1:0]      green_out,
	output logic [CHANNEL_BITS-1:0]      blue_out,
	output logic [AW-1:0]                out_col,
	output logic [AW-1:0]                out_row
);

	localparam int S_W   = $clog2(MAX_FACTOR + 1);
	localparam int N_W   = $clog2(MAX_OUT_SIZE + 1);
	localparam int T_W   = $clog2(MAX_OUT_SIZE * MAX_FACTOR + 1);
	localparam int PH_W  = (MAX_FACTOR > 1) ? $clog2(MAX_FACTOR) : 1;
	localparam int CNT_W = $clog2(MAX_FACTOR * MAX_FACTOR + 1);
	localparam int SUM_W = CHANNEL_BITS + $clog2(MAX_FACTOR * MAX_FACTOR);
	localparam int DC_W  = $clog2(SUM_W + 1);

	localparam int RST_S = (RST_FACTOR > MAX_FACTOR) ? MAX_FACTOR : RST_FACTOR;
	localparam int RST_N = (RST_OUT_SIZE > MAX_OUT_SIZE) ? MAX_OUT_SIZE : RST_OUT_SIZE;

	typedef logic [2:0][SUM_W-1:0]        sums_t;
	typedef logic [2:0][CHANNEL_BITS-1:0] rgb_t;

	typedef enum logic [1:0] {
		DIV_IDLE,
		DIV_RUN,
		DIV_DONE
	} div_state_t;

	// configuration, held as effective values
	logic [S_W-1:0] s_q;
	logic [N_W-1:0] n_q;
	logic [T_W-1:0] total_q;

	// frame position
	logic [T_W-1:0]  c_q, r_q;
	logic [PH_W-1:0] pc_q, pr_q;
	logic [N_W-1:0]  wx_q, wy_q;

	// stage 1
	logic             valid_s1, first_s1, last_s1;
	logic [AW-1:0]    addr_s1, row_s1;
	logic [CNT_W-1:0] cnt_s1;
	rgb_t             smp_s1;

	// memory and bypass
	sums_t          sums_mem [MAX_OUT_SIZE];
	sums_t          rd_q, wr_data_q, oper, new_sum;
	logic           wr_valid_q;
	logic [AW-1:0]  wr_addr_q;

	// divider and output
	div_state_t                 div_state_q;
	sums_t                      quo_q;
	logic [2:0][CNT_W-1:0]      rem_q, rem_nx;
	sums_t                      quo_nx;
	logic [CNT_W-1:0]           dsr_q;
	logic [DC_W-1:0]            dcnt_q;
	logic [AW-1:0]              dcol_q, drow_q;
	logic                       result_valid_q;
	rgb_t                       out_rgb_q;
	logic [AW-1:0]              out_col_q, out_row_q;
	logic                       out_load;

	logic             cfg_wr, accept, start_div;
	logic [S_W-1:0]   s_new, h_new, h_cur, s_m1, rows, cols;
	logic [N_W-1:0]   n_new;
	logic [T_W-1:0]   total_new;
	logic             col_in, row_in, col_first, row_first, win_last;
	logic [FACTOR_W-1:0]   raw_f;
	logic [OUT_SIZE_W-1:0] raw_n;

	assign cfg_ready    = 1'b1;
	assign cfg_wr       = cfg_valid && cfg_ready;
	assign start_div    = valid_s1 && last_s1;
	assign sample_stall = (div_state_q != DIV_IDLE) || start_div;
	assign accept       = sample_valid && !sample_stall;
	assign out_load     = (div_state_q == DIV_DONE) && (!result_valid_q || !result_stall);

	always_comb begin
		raw_f = cfg_data[FACTOR_W-1:0];
		raw_n = cfg_data[OUT_SIZE_W-1:0];
		if (raw_f == '0)
			s_new = S_W'(1);
		else if (int'(raw_f) > MAX_FACTOR)
			s_new = S_W'(MAX_FACTOR);
		else
			s_new = S_W'(raw_f);
		if (raw_n == '0)
			n_new = N_W'(1);
		else if (int'(raw_n) > MAX_OUT_SIZE)
			n_new = N_W'(MAX_OUT_SIZE);
		else
			n_new = N_W'(raw_n);
		if (cfg_index == REG_FACTOR)
			total_new = T_W'(n_q) * T_W'(s_new);
		else
			total_new = T_W'(n_new) * T_W'(s_q);
		h_new = s_new >> 1;
	end

	always_comb begin
		h_cur     = s_q >> 1;
		s_m1      = s_q - 1'b1;
		col_in    = wx_q < n_q;
		row_in    = wy_q < n_q;
		col_first = (wx_q == '0) ? (c_q == '0) : (pc_q == '0);
		row_first = (wy_q == '0) ? (r_q == '0) : (pr_q == '0);
		win_last  = (S_W'(pc_q) == s_m1) && (S_W'(pr_q) == s_m1);
		cols      = (wx_q == '0) ? (s_q - h_cur) : s_q;
		rows      = (wy_q == '0) ? (s_q - h_cur) : s_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_q     <= S_W'(RST_S);
			n_q     <= N_W'(RST_N);
			total_q <= T_W'(RST_S * RST_N);
			c_q     <= '0;
			r_q     <= '0;
			pc_q    <= PH_W'(RST_S / 2);
			pr_q    <= PH_W'(RST_S / 2);
			wx_q    <= '0;
			wy_q    <= '0;
		end else if (cfg_wr) begin
			if (cfg_index == REG_FACTOR || cfg_index == REG_OUT_SIZE) begin
				if (cfg_index == REG_FACTOR)
					s_q <= s_new;
				else
					n_q <= n_new;
				total_q <= total_new;
				c_q     <= '0;
				r_q     <= '0;
				wx_q    <= '0;
				wy_q    <= '0;
				pc_q    <= (cfg_index == REG_FACTOR) ? PH_W'(h_new) : PH_W'(h_cur);
				pr_q    <= (cfg_index == REG_FACTOR) ? PH_W'(h_new) : PH_W'(h_cur);
			end
		end else if (accept) begin
			if (c_q == total_q - 1'b1) begin
				c_q  <= '0;
				pc_q <= PH_W'(h_cur);
				wx_q <= '0;
				if (r_q == total_q - 1'b1) begin
					r_q  <= '0;
					pr_q <= PH_W'(h_cur);
					wy_q <= '0;
				end else begin
					r_q <= r_q + 1'b1;
					if (S_W'(pr_q) == s_m1) begin
						pr_q <= '0;
						wy_q <= wy_q + 1'b1;
					end else begin
						pr_q <= pr_q + 1'b1;
					end
				end
			end else begin
				c_q <= c_q + 1'b1;
				if (S_W'(pc_q) == s_m1) begin
					pc_q <= '0;
					wx_q <= wx_q + 1'b1;
				end else begin
					pc_q <= pc_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			wr_valid_q <= 1'b0;
		end else begin
			valid_s1   <= accept && col_in && row_in;
			wr_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			addr_s1   <= wx_q[AW-1:0];
			row_s1    <= wy_q[AW-1:0];
			first_s1  <= col_first && row_first;
			last_s1   <= win_last;
			cnt_s1    <= CNT_W'(rows) * CNT_W'(cols);
			smp_s1[0] <= red_in;
			smp_s1[1] <= green_in;
			smp_s1[2] <= blue_in;
		end
		wr_addr_q <= addr_s1;
		wr_data_q <= new_sum;
	end

	// read-modify-write, with bypass of the write made while this entry was being read
	always_comb begin
		oper = (wr_valid_q && wr_addr_q == addr_s1) ? wr_data_q : rd_q;
		for (int k = 0; k < 3; k++)
			new_sum[k] = first_s1 ? SUM_W'(smp_s1[k]) : oper[k] + SUM_W'(smp_s1[k]);
	end

	always_ff @(posedge clk) begin
		if (valid_s1)
			sums_mem[addr_s1] <= new_sum;
		if (accept)
			rd_q <= sums_mem[wx_q[AW-1:0]];
	end

	// one quotient bit per channel per cycle
	always_comb begin
		logic [CNT_W:0] trial;
		logic           ge;
		for (int k = 0; k < 3; k++) begin
			trial     = {rem_q[k], quo_q[k][SUM_W-1]};
			ge        = trial >= {1'b0, dsr_q};
			rem_nx[k] = ge ? CNT_W'(trial - {1'b0, dsr_q}) : trial[CNT_W-1:0];
			quo_nx[k] = {quo_q[k][SUM_W-2:0], ge};
		end
	end

	always_ff @(posedge clk) begin
		if (div_state_q == DIV_IDLE && start_div) begin
			quo_q  <= new_sum;
			rem_q  <= '0;
			dsr_q  <= cnt_s1;
			dcol_q <= addr_s1;
			drow_q <= row_s1;
		end else if (div_state_q == DIV_RUN) begin
			quo_q <= quo_nx;
			rem_q <= rem_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_state_q    <= DIV_IDLE;
			dcnt_q         <= '0;
			result_valid_q <= 1'b0;
			out_rgb_q      <= '0;
			out_col_q      <= '0;
			out_row_q      <= '0;
		end else begin
			if (out_load)
				result_valid_q <= 1'b1;
			else if (!result_stall)
				result_valid_q <= 1'b0;
			unique case (div_state_q)
				DIV_IDLE: begin
					if (start_div) begin
						dcnt_q      <= DC_W'(SUM_W);
						div_state_q <= DIV_RUN;
					end
				end
				DIV_RUN: begin
					dcnt_q <= dcnt_q - 1'b1;
					if (dcnt_q == DC_W'(1))
						div_state_q <= DIV_DONE;
				end
				DIV_DONE: begin
					if (out_load) begin
						for (int k = 0; k < 3; k++)
							out_rgb_q[k] <= quo_q[k][CHANNEL_BITS-1:0];
						out_col_q   <= dcol_q;
						out_row_q   <= drow_q;
						div_state_q <= DIV_IDLE;
					end
				end
				default: div_state_q <= DIV_IDLE;
			endcase
		end
	end

	assign result_valid = result_valid_q;
	assign red_out      = out_rgb_q[0];
	assign green_out    = out_rgb_q[1];
	assign blue_out     = out_rgb_q[2];
	assign out_col      = out_col_q;
	assign out_row      = out_row_q;

`ifndef SYNTHESIS
	a_div_launch: assert property (@(posedge clk) disable iff (!arst_n)
		(div_state_q == DIV_IDLE && start_div) |=> (div_state_q == DIV_RUN))
		else $error("divider not launched by closing sample");

	a_phase_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(S_W'(pc_q) < s_q) && (S_W'(pr_q) < s_q))
		else $error("window phase beyond factor");

	a_cfg_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_wr && (cfg_index == REG_FACTOR || cfg_index == REG_OUT_SIZE))
		|=> (c_q == '0 && r_q == '0 && wx_q == '0 && wy_q == '0))
		else $error("register write did not restart frame");

	a_done_from_run: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(div_state_q == DIV_DONE) |-> ($past(div_state_q) == DIV_RUN))
		else $error("divider finished without running");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(div_state_q == DIV_DONE && result_valid_q && result_stall)
		|=> (div_state_q == DIV_DONE && $stable(out_rgb_q)))
		else $error("pending result overwritten");
`endif

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// Self-checking testbench for supersample_box_downsample: random sample frames scored against a box-average predictor.
`timescale 1ns / 100ps

module tb_top;
	import ssbd_pkg::*;

	localparam int CHAN_W        = DEF_CHANNEL_BITS;
	localparam int COORD_W       = $clog2(DEF_MAX_OUT_SIZE);
	localparam int SUM_BITS      = CHAN_W + 2 * $clog2(DEF_MAX_FACTOR);
	localparam int SETTLE_CYCLES = 48;
	localparam int CYCLE_LIMIT   = 2000000;
	localparam int SAMPLE_BUDGET = 1900;
	localparam int HOLD_CYCLES   = 400;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd2;
	localparam logic [CHAN_W-1:0] CHAN_ZERO = '0;
	localparam logic [CHAN_W-1:0] CHAN_MAX  = '1;
	localparam logic [CHAN_W-1:0] CHAN_EVEN = 12'hAAA;
	localparam logic [CHAN_W-1:0] CHAN_ODD  = 12'h555;

	typedef logic [2:0][CHAN_W-1:0] rgb_t;

	typedef struct packed {
		logic [CHAN_W-1:0]  red;
		logic [CHAN_W-1:0]  green;
		logic [CHAN_W-1:0]  blue;
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
	} pixel_t;

	class window_average_board;
		logic [FACTOR_W-1:0]   factor_reg;
		logic [OUT_SIZE_W-1:0] size_reg;
		int unsigned           next_col;
		int unsigned           next_row;
		logic [SUM_BITS-1:0]   col_sum [DEF_MAX_OUT_SIZE][3];
		pixel_t                pending_pixels [$];
		int unsigned           error_count;
		int unsigned           pixels_checked;

		function new();
			factor_reg = RST_FACTOR;
			size_reg = RST_OUT_SIZE;
			next_col = 0;
			next_row = 0;
			error_count = 0;
			pixels_checked = 0;
		endfunction

		function int unsigned factor_eff();
			if (factor_reg == 0)
				return 1;
			if (factor_reg > DEF_MAX_FACTOR)
				return DEF_MAX_FACTOR;
			return factor_reg;
		endfunction

		function int unsigned size_eff();
			if (size_reg == 0)
				return 1;
			if (size_reg > DEF_MAX_OUT_SIZE)
				return DEF_MAX_OUT_SIZE;
			return size_reg;
		endfunction

		function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
			REG_FACTOR: begin
				factor_reg = data[FACTOR_W-1:0];
				next_col = 0;
				next_row = 0;
			end
			REG_OUT_SIZE: begin
				size_reg = data[OUT_SIZE_W-1:0];
				next_col = 0;
				next_row = 0;
			end
			default: ;
			endcase
		endfunction

		function void take_sample(rgb_t smp);
			int unsigned s, n, h, wx, wy, sr, sc, cnt;
			bit opens, closes;
			pixel_t px;
			s = factor_eff();
			n = size_eff();
			h = s / 2;
			wx = (next_col + h) / s;
			wy = (next_row + h) / s;
			if (wx < n && wy < n) begin
				sr = (wy * s >= h) ? wy * s - h : 0;
				sc = (wx * s >= h) ? wx * s - h : 0;
				opens = next_row == sr && next_col == sc;
				closes = next_row + h == wy * s + s - 1 && next_col + h == wx * s + s - 1;
				for (int k = 0; k < 3; k++)
					col_sum[wx][k] = opens ? SUM_BITS'(smp[k]) : col_sum[wx][k] + smp[k];
				if (closes) begin
					cnt = (next_row + 1 - sr) * (next_col + 1 - sc);
					px.red = CHAN_W'(col_sum[wx][0] / cnt);
					px.green = CHAN_W'(col_sum[wx][1] / cnt);
					px.blue = CHAN_W'(col_sum[wx][2] / cnt);
					px.col = COORD_W'(wx);
					px.row = COORD_W'(wy);
					pending_pixels = {pending_pixels, px};
				end
			end
			if (next_col + 1 >= n * s) begin
				next_col = 0;
				next_row = (next_row + 1 >= n * s) ? 0 : next_row + 1;
			end else begin
				next_col++;
			end
		endfunction

		function void compare_field(string name, logic [CHAN_W-1:0] want, logic [CHAN_W-1:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				error_count++;
			end
		endfunction

		function void check_pixel(pixel_t got);
			pixel_t want;
			pixels_checked++;
			if (pending_pixels.size() == 0) begin
				$error("pixel col %0d row %0d arrived with none outstanding", got.col, got.row);
				error_count++;
				return;
			end
			want = pending_pixels.pop_front();
			compare_field("red_out", want.red, got.red);
			compare_field("green_out", want.green, got.green);
			compare_field("blue_out", want.blue, got.blue);
			compare_field("out_col", want.col, got.col);
			compare_field("out_row", want.row, got.row);
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_FACTOR;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  sample_valid = 1'b0;
	logic                  sample_stall;
	logic [CHAN_W-1:0]     red_in = '0;
	logic [CHAN_W-1:0]     green_in = '0;
	logic [CHAN_W-1:0]     blue_in = '0;
	logic                  result_valid;
	logic                  result_stall = 1'b0;
	logic [CHAN_W-1:0]     red_out;
	logic [CHAN_W-1:0]     green_out;
	logic [CHAN_W-1:0]     blue_out;
	logic [COORD_W-1:0]    out_col;
	logic [COORD_W-1:0]    out_row;

	window_average_board board = new();
	bit                  send_gappy = 1'b0;
	bit                  rx_calm = 1'b0;
	int unsigned         samples_sent = 0;
	int unsigned         cycle_count = 0;

	supersample_box_downsample dut (.*);

	always #5 clk = ~clk;

	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 65)
			return 0;
		if (roll < 93)
			return $urandom_range(1, 3);
		return $urandom_range(10, 50);
	endfunction

	function automatic logic [CHAN_W-1:0] pick_channel();
		case ($urandom_range(0, 7))
		0: return CHAN_ZERO;
		1: return CHAN_MAX;
		default: return CHAN_W'($urandom);
		endcase
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_factor_data();
		int unsigned roll;
		logic [FACTOR_W-1:0] nib;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			nib = FACTOR_W'($urandom_range(1, 4));
		else if (roll < 70)
			nib = '0;
		else if (roll < 85)
			nib = FACTOR_W'($urandom_range(5, DEF_MAX_FACTOR));
		else
			nib = FACTOR_W'($urandom_range(DEF_MAX_FACTOR + 1, 15));
		return {(CFG_DATA_W - FACTOR_W)'($urandom), nib};
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_size_data();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 65)
			return CFG_DATA_W'($urandom_range(1, 4));
		if (roll < 73)
			return '0;
		if (roll < 93)
			return CFG_DATA_W'($urandom_range(5, 12));
		return CFG_DATA_W'($urandom_range(13, 2047));
	endfunction

	task automatic send_sample(rgb_t smp);
		int unsigned gap;
		gap = send_gappy ? pick_gap() : 0;
		if (gap > 0) begin
			sample_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		sample_valid = 1'b1;
		red_in = smp[0];
		green_in = smp[1];
		blue_in = smp[2];
		do @(posedge clk); while (sample_stall);
		board.take_sample(smp);
		samples_sent++;
		@(negedge clk);
	endtask

	task automatic send_random(int unsigned count);
		rgb_t smp;
		repeat (count) begin
			smp = {pick_channel(), pick_channel(), pick_channel()};
			send_sample(smp);
		end
		sample_valid = 1'b0;
	endtask

	// let every expected pixel arrive and any request still in flight drain before touching the registers
	task automatic wait_idle();
		sample_valid = 1'b0;
		while (board.pending_pixels.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		do @(posedge clk); while (!cfg_ready);
		board.write_register(idx, data);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	initial begin
		int unsigned frame, count;
		logic [CFG_DATA_W-1:0] fdata, sdata;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset settings: factor 2, full-size image, top row of shortened windows
		send_sample({CHAN_MAX, CHAN_MAX, CHAN_MAX});
		send_sample({CHAN_ZERO, CHAN_ZERO, CHAN_ZERO});
		send_sample({CHAN_ODD, CHAN_ZERO, CHAN_MAX});
		send_sample({CHAN_MAX, CHAN_ODD, CHAN_EVEN});
		send_sample({CHAN_ZERO, CHAN_EVEN, CHAN_ODD});
		send_sample({CHAN_MAX, CHAN_MAX, CHAN_MAX});
		send_sample({CHAN_MAX, CHAN_MAX, CHAN_MAX});
		send_sample({CHAN_EVEN, CHAN_MAX, CHAN_ZERO});
		sample_valid = 1'b0;
		// unused index: frame position must survive
		wait_idle();
		write_register(REG_SPARE, '1);
		send_sample({CHAN_ODD, CHAN_ODD, CHAN_ODD});
		send_sample({CHAN_EVEN, CHAN_EVEN, CHAN_EVEN});
		sample_valid = 1'b0;
		// zero factor and size act as one
		wait_idle();
		write_register(REG_FACTOR, '0);
		write_register(REG_OUT_SIZE, '0);
		send_random(3);
		// high data bits ignored; trailing row and column dropped
		wait_idle();
		write_register(REG_FACTOR, 11'h7F2);
		write_register(REG_OUT_SIZE, 11'd1);
		send_random(4);
		wait_idle();
		write_register(REG_FACTOR, 11'd3);
		send_random(9);

		send_gappy = 1'b1;
		wait_idle();
		write_register(REG_FACTOR, 11'd1);
		write_register(REG_OUT_SIZE, '1);
		send_random(60);
		wait_idle();
		write_register(REG_FACTOR, 11'd9);
		write_register(REG_OUT_SIZE, 11'd2);
		send_random(256);

		while (samples_sent < SAMPLE_BUDGET) begin
			fdata = pick_factor_data();
			sdata = pick_size_data();
			wait_idle();
			case ($urandom_range(0, 3))
			0: write_register(REG_FACTOR, fdata);
			1: write_register(REG_OUT_SIZE, sdata);
			default: begin
				write_register(REG_FACTOR, fdata);
				write_register(REG_OUT_SIZE, sdata);
			end
			endcase
			frame = board.size_eff() * board.factor_eff();
			frame = frame * frame;
			if (frame <= 400 && $urandom_range(0, 9) != 0)
				count = frame * $urandom_range(1, 2);
			else
				count = $urandom_range(5, 150);
			if (count > SAMPLE_BUDGET - samples_sent)
				count = SAMPLE_BUDGET - samples_sent;
			send_gappy = $urandom_range(0, 2) != 0;
			send_random(count);
		end

		wait_idle();
		if (board.error_count == 0 && board.pending_pixels.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		int unsigned burst, hold_left, hold_mark;
		burst = 0;
		hold_left = 0;
		hold_mark = 30;
		forever begin
			@(negedge clk);
			if (board.pixels_checked >= hold_mark) begin
				hold_left = HOLD_CYCLES;
				hold_mark += 700;
			end
			if ($urandom_range(0, 499) == 0)
				rx_calm = !rx_calm;
			if (hold_left > 0) begin
				hold_left--;
				result_stall = 1'b1;
			end else if (burst > 0) begin
				burst--;
				result_stall = 1'b1;
			end else begin
				result_stall = 1'b0;
				if (!rx_calm && $urandom_range(0, 3) == 0)
					burst = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			board.check_pixel({red_out, green_out, blue_out, out_col, out_row});
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

endmodule

/* files.f */
hdl/ssbd_pkg.sv
hdl/supersample_box_downsample.sv
tb/tb_top.sv
